>>> sv/psd_pkg.sv
// Shared types and constants for the point to segment distance block.
// Used by psd_front, psd_fifo, psd_back and point_segment_distance.
package psd_pkg;

    localparam int CW        = 16;  // coordinate width, signed Q8.8
    localparam int DW        = 17;  // coordinate difference width
    localparam int LW        = 33;  // squared length width, unsigned
    localparam int PW        = 34;  // dot product width, signed
    localparam int TW        = 17;  // projection parameter width, t <= 1.0
    localparam int RW        = 17;  // distance width
    localparam int T_FRAC    = 16;  // fraction bits of t
    localparam int QDEPTH    = 4;   // queue entries
    localparam int QAW       = 2;   // queue address bits

    typedef enum logic [1:0] {
        CASE_DEGEN    = 2'd0,
        CASE_BEFORE   = 2'd1,
        CASE_BEYOND   = 2'd2,
        CASE_INTERIOR = 2'd3
    } t_case;

    // One query with its differences, squared length and dot product, as it travels from the front to the back.
    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic        [LW-1:0] len2;
        logic signed [PW-1:0] dot;
    } t_item;

endpackage

>>> sv/psd_front.sv
// Front end: registers a query, forms the segment vector, the squared
// length and the dot product, and pushes the result into the queue. Uses psd_pkg.
module psd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [psd_pkg::CW-1:0] i_seg_ax,
    input  logic signed [psd_pkg::CW-1:0] i_seg_ay,
    input  logic signed [psd_pkg::CW-1:0] i_seg_bx,
    input  logic signed [psd_pkg::CW-1:0] i_seg_by,
    input  logic signed [psd_pkg::CW-1:0] i_query_x,
    input  logic signed [psd_pkg::CW-1:0] i_query_y,
    input  logic                          i_full,
    output logic                          o_push,
    output psd_pkg::t_item                o_item
);

    logic                          r_v1, r_v2;
    logic signed [psd_pkg::CW-1:0] r_ax, r_ay, r_bx, r_by, r_px, r_py;
    logic signed [psd_pkg::CW-1:0] r_ax2, r_ay2, r_bx2, r_by2, r_px2, r_py2;
    logic signed [psd_pkg::DW-1:0] r_dx2, r_dy2;
    logic signed [psd_pkg::PW-1:0] r_pdd, r_pee, r_pwd, r_pwe;
    logic signed [psd_pkg::DW-1:0] dx, dy, wx, wy;
    logic                          adv;

    assign adv     = !r_v2 || !i_full;
    assign o_ready = adv;
    assign o_push  = r_v2 && !i_full;

    assign dx = psd_pkg::DW'(r_bx) - psd_pkg::DW'(r_ax);
    assign dy = psd_pkg::DW'(r_by) - psd_pkg::DW'(r_ay);
    assign wx = psd_pkg::DW'(r_px) - psd_pkg::DW'(r_ax);
    assign wy = psd_pkg::DW'(r_py) - psd_pkg::DW'(r_ay);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ax  <= i_seg_ax;
            r_ay  <= i_seg_ay;
            r_bx  <= i_seg_bx;
            r_by  <= i_seg_by;
            r_px  <= i_query_x;
            r_py  <= i_query_y;
            r_ax2 <= r_ax;
            r_ay2 <= r_ay;
            r_bx2 <= r_bx;
            r_by2 <= r_by;
            r_px2 <= r_px;
            r_py2 <= r_py;
            r_dx2 <= dx;
            r_dy2 <= dy;
            r_pdd <= dx * dx;
            r_pee <= dy * dy;
            r_pwd <= wx * dx;
            r_pwe <= wy * dy;
        end
    end

    always_comb begin
        o_item.ax   = r_ax2;
        o_item.ay   = r_ay2;
        o_item.bx   = r_bx2;
        o_item.by   = r_by2;
        o_item.px   = r_px2;
        o_item.py   = r_py2;
        o_item.dx   = r_dx2;
        o_item.dy   = r_dy2;
        // Each square is below 2^32, so the sum fits the unsigned length field.
        o_item.len2 = {1'b0, r_pdd[31:0]} + {1'b0, r_pee[31:0]};
        o_item.dot  = r_pwd + r_pwe;
    end

endmodule

>>> sv/psd_fifo.sv
// Short queue that decouples the front end from the back end.
// Holds psd_pkg::t_item entries; uses psd_pkg.
module psd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  psd_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output psd_pkg::t_item o_item
);

    psd_pkg::t_item               r_mem [psd_pkg::QDEPTH];
    logic [psd_pkg::QAW-1:0]      r_wr, r_rd;
    logic [psd_pkg::QAW:0]        r_cnt;
    logic                         do_pop;

    assign o_full  = (r_cnt == (psd_pkg::QAW+1)'(psd_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (psd_pkg::QAW+1)'(i_push) - (psd_pkg::QAW+1)'(do_pop);
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (psd_pkg::QAW+1)'(psd_pkg::QDEPTH))
        else $error("queue count exceeds depth");

    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_cnt == $past(r_cnt) + (psd_pkg::QAW+1)'($past(i_push))
                          - (psd_pkg::QAW+1)'($past(do_pop)))
        else $error("queue count does not follow transfers");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr - r_rd) == r_cnt[psd_pkg::QAW-1:0])
        else $error("queue pointers disagree with count");

endmodule

>>> sv/psd_back.sv
// Back end: pipelined divider for t, classification, interpolation of the
// closest point, squared error and a pipelined integer square root. Uses psd_pkg.
module psd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  psd_pkg::t_item                i_item,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [psd_pkg::RW-1:0]        o_distance,
    output logic signed [psd_pkg::CW-1:0] o_closest_x,
    output logic signed [psd_pkg::CW-1:0] o_closest_y,
    output logic [1:0]                    o_case_code
);

    localparam int NDIV = psd_pkg::TW - 1;   // divider stages after the first bit
    localparam int NSQ  = psd_pkg::RW;       // one root bit per stage
    localparam int SQW  = 35;                // square root working width

    typedef struct packed {
        logic signed [psd_pkg::CW-1:0] ax, ay, bx, by, px, py;
        logic signed [psd_pkg::DW-1:0] dx, dy;
        logic        [psd_pkg::LW-1:0] len2;
        logic        [psd_pkg::LW-1:0] rem;
        logic        [psd_pkg::TW-1:0] q;
        logic                          neg, degen, over;
    } t_dv;

    typedef struct packed {
        logic signed [psd_pkg::CW-1:0] ax, ay, bx, by, px, py;
        logic                          sx, sy;
        logic        [32:0]            mx, my;
        psd_pkg::t_case                code;
    } t_cl;

    typedef struct packed {
        logic signed [psd_pkg::CW-1:0] qx, qy;
        logic signed [psd_pkg::DW-1:0] ex, ey;
        psd_pkg::t_case                code;
    } t_qp;

    typedef struct packed {
        logic signed [psd_pkg::CW-1:0] qx, qy;
        logic        [SQW-1:0]         rem;
        logic        [psd_pkg::RW-1:0] root;
        psd_pkg::t_case                code;
    } t_sq;

    logic                           en;
    logic [NDIV:0]                  r_dv_v;
    t_dv                            r_dv [NDIV+1];
    logic                           r_cl_v, r_qp_v, r_sp_v;
    t_cl                            r_cl;
    t_qp                            r_qp, r_sp;
    logic        [2*psd_pkg::DW-1:0] r_pex, r_pey;
    logic [NSQ:0]                   r_sq_v;
    t_sq                            r_sq [NSQ+1];
    logic                           r_ov;

    // Whole back end advances together whenever the output slot can move.
    assign en      = !r_ov || i_ready;
    assign o_pop   = en && i_valid;
    assign o_valid = r_ov;

    // First divider stage: magnitude, range checks and the top quotient bit.
    logic [psd_pkg::PW-1:0] mag_w;
    logic [psd_pkg::LW-1:0] mag;
    t_dv                    dv0;
    always_comb begin
        mag_w     = i_item.dot[psd_pkg::PW-1] ? psd_pkg::PW'(-i_item.dot)
                                              : psd_pkg::PW'(i_item.dot);
        mag       = mag_w[psd_pkg::LW-1:0];
        dv0.ax    = i_item.ax;
        dv0.ay    = i_item.ay;
        dv0.bx    = i_item.bx;
        dv0.by    = i_item.by;
        dv0.px    = i_item.px;
        dv0.py    = i_item.py;
        dv0.dx    = i_item.dx;
        dv0.dy    = i_item.dy;
        dv0.len2  = i_item.len2;
        dv0.neg   = i_item.dot[psd_pkg::PW-1];
        dv0.degen = (i_item.len2 == '0);
        // t of two or more is certainly beyond either end.
        dv0.over  = {1'b0, mag} >= {i_item.len2, 1'b0};
        dv0.q     = '0;
        dv0.q[psd_pkg::TW-1] = (mag >= i_item.len2);
        dv0.rem   = (mag >= i_item.len2) ? mag - i_item.len2 : mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (en) begin
            r_dv_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv[0] <= dv0;
        end
    end

    // Restoring division, one quotient bit per stage.
    for (genvar j = 1; j <= NDIV; j++) begin : g_div
        logic [psd_pkg::LW:0] r2;
        logic                 ge;
        t_dv                  nx;
        always_comb begin
            r2 = {r_dv[j-1].rem, 1'b0};
            ge = r2 >= {1'b0, r_dv[j-1].len2};
            nx = r_dv[j-1];
            nx.q[NDIV-j] = ge;
            nx.rem = ge ? psd_pkg::LW'(r2 - {1'b0, r_dv[j-1].len2})
                        : psd_pkg::LW'(r2);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else if (en) begin
                r_dv_v[j] <= r_dv_v[j-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[j] <= nx;
            end
        end
    end

    // Classification and the scale of the segment vector by t.
    t_dv                    dl;
    t_cl                    cl;
    logic [psd_pkg::TW-1:0] t;
    logic [psd_pkg::DW-1:0] adx, ady;
    always_comb begin
        dl = r_dv[NDIV];
        t  = '0;
        if (dl.degen) begin
            cl.code = psd_pkg::CASE_DEGEN;
        end else if (dl.neg && (dl.over || dl.q != '0)) begin
            cl.code = psd_pkg::CASE_BEFORE;
        end else if (!dl.neg && (dl.over ||
                     dl.q > psd_pkg::TW'(1 << psd_pkg::T_FRAC))) begin
            cl.code = psd_pkg::CASE_BEYOND;
        end else begin
            cl.code = psd_pkg::CASE_INTERIOR;
            t       = dl.neg ? '0 : dl.q;
        end
        adx   = dl.dx[psd_pkg::DW-1] ? psd_pkg::DW'(-dl.dx) : psd_pkg::DW'(dl.dx);
        ady   = dl.dy[psd_pkg::DW-1] ? psd_pkg::DW'(-dl.dy) : psd_pkg::DW'(dl.dy);
        cl.mx = 33'(adx[15:0]) * 33'(t);
        cl.my = 33'(ady[15:0]) * 33'(t);
        cl.sx = dl.dx[psd_pkg::DW-1];
        cl.sy = dl.dy[psd_pkg::DW-1];
        cl.ax = dl.ax;
        cl.ay = dl.ay;
        cl.bx = dl.bx;
        cl.by = dl.by;
        cl.px = dl.px;
        cl.py = dl.py;
    end

    // Closest point: offset truncated toward zero, then the error vector.
    t_qp              qp;
    logic [16:0]      mofx, mofy;
    logic signed [17:0] offx, offy, sumx, sumy;
    always_comb begin
        mofx = r_cl.mx[32:psd_pkg::T_FRAC];
        mofy = r_cl.my[32:psd_pkg::T_FRAC];
        offx = r_cl.sx ? -$signed(18'(mofx)) : $signed(18'(mofx));
        offy = r_cl.sy ? -$signed(18'(mofy)) : $signed(18'(mofy));
        sumx = 18'(r_cl.ax) + offx;
        sumy = 18'(r_cl.ay) + offy;
        case (r_cl.code)
            psd_pkg::CASE_INTERIOR: begin
                qp.qx = sumx[15:0];
                qp.qy = sumy[15:0];
            end
            psd_pkg::CASE_BEYOND: begin
                qp.qx = r_cl.bx;
                qp.qy = r_cl.by;
            end
            default: begin
                qp.qx = r_cl.ax;
                qp.qy = r_cl.ay;
            end
        endcase
        qp.ex   = psd_pkg::DW'(r_cl.px) - psd_pkg::DW'(qp.qx);
        qp.ey   = psd_pkg::DW'(r_cl.py) - psd_pkg::DW'(qp.qy);
        qp.code = r_cl.code;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cl_v    <= 1'b0;
            r_qp_v    <= 1'b0;
            r_sp_v    <= 1'b0;
            r_sq_v[0] <= 1'b0;
        end else if (en) begin
            r_cl_v    <= r_dv_v[NDIV];
            r_qp_v    <= r_cl_v;
            r_sp_v    <= r_qp_v;
            r_sq_v[0] <= r_sp_v;
        end
    end

    t_sq sq0;
    always_comb begin
        sq0.qx   = r_sp.qx;
        sq0.qy   = r_sp.qy;
        sq0.code = r_sp.code;
        sq0.root = '0;
        sq0.rem  = SQW'(r_pex[31:0]) + SQW'(r_pey[31:0]);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cl    <= cl;
            r_qp    <= qp;
            r_sp    <= r_qp;
            r_pex   <= r_qp.ex * r_qp.ex;
            r_pey   <= r_qp.ey * r_qp.ey;
            r_sq[0] <= sq0;
        end
    end

    // Digit by digit square root, one result bit per stage, high bit first.
    for (genvar s = 1; s <= NSQ; s++) begin : g_sqrt
        localparam int B = NSQ - s;
        logic [SQW-1:0] trial;
        t_sq            nx;
        always_comb begin
            trial = (SQW'(r_sq[s-1].root) << (B + 1)) + (SQW'(1) << (2 * B));
            nx    = r_sq[s-1];
            if (r_sq[s-1].rem >= trial) begin
                nx.rem     = r_sq[s-1].rem - trial;
                nx.root[B] = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[s] <= 1'b0;
            end else if (en) begin
                r_sq_v[s] <= r_sq_v[s-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq[s] <= nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_sq_v[NSQ];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_distance  <= r_sq[NSQ].root;
            o_closest_x <= r_sq[NSQ].qx;
            o_closest_y <= r_sq[NSQ].qy;
            o_case_code <= r_sq[NSQ].code;
        end
    end

endmodule

>>> sv/point_segment_distance.sv
// Top level of the point to segment distance block.
// Instantiates psd_front, psd_fifo and psd_back; uses psd_pkg.
//
// Each transfer on the input carries a segment A to B and a query point P,
// all signed Q8.8, and yields exactly one output transfer with the closest
// point Q on the segment, the floor square root distance |P - Q| in
// unsigned Q9.8, and a case code (degenerate, before start, beyond end,
// interior). Items are independent and results leave in input order. The
// block accepts one item per clock cycle while its queue has room and
// delivers one per cycle while the output side is ready. From the input
// transfer an item passes the input registers, then one front stage for
// the differences and the four 17 by 17 products, one queue write,
// seventeen divider stages that produce t one quotient bit each,
// three stages for classification, interpolation and the squared error,
// one summing stage, seventeen square root stages, and the output
// register. The front and back run on separate handshakes with
// a four entry queue between them, so an output stall first fills the
// queue before the input side stops; the back end itself holds as a whole
// while its output register is full and not being taken.
module point_segment_distance (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [psd_pkg::CW-1:0] i_seg_ax,
    input  logic signed [psd_pkg::CW-1:0] i_seg_ay,
    input  logic signed [psd_pkg::CW-1:0] i_seg_bx,
    input  logic signed [psd_pkg::CW-1:0] i_seg_by,
    input  logic signed [psd_pkg::CW-1:0] i_query_x,
    input  logic signed [psd_pkg::CW-1:0] i_query_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [psd_pkg::RW-1:0]        o_distance,
    output logic signed [psd_pkg::CW-1:0] o_closest_x,
    output logic signed [psd_pkg::CW-1:0] o_closest_y,
    output logic [1:0]                    o_case_code
);

    logic           push, full, pop, q_valid;
    psd_pkg::t_item push_item, q_item;

    // The front end computes the dot product and squared length.
    psd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_seg_ax  (i_seg_ax),
        .i_seg_ay  (i_seg_ay),
        .i_seg_bx  (i_seg_bx),
        .i_seg_by  (i_seg_by),
        .i_query_x (i_query_x),
        .i_query_y (i_query_y),
        .i_full    (full),
        .o_push    (push),
        .o_item    (push_item)
    );

    // The queue lets the front keep accepting while the back is stalled.
    psd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // The back end divides, interpolates and takes the square root.
    psd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_distance  (o_distance),
        .o_closest_x (o_closest_x),
        .o_closest_y (o_closest_y),
        .o_case_code (o_case_code)
    );

endmodule
